// ----- rtl/core/ikarm_pkg.sv -----
`default_nettype none
package ikarm_pkg;

  localparam int LW = 23;           // link length, unsigned Q7.16
  localparam int PW = 24;           // position, signed Q7.16
  localparam int AW = 18;           // angle, signed Q3.14
  localparam int CW = 36;           // CORDIC x/y datapath
  localparam int ZW = 25;           // CORDIC angle accumulator, Q20
  localparam int NW = 52;           // law-of-cosines numerator/denominator
  localparam int SW = 64;           // square-root datapath
  localparam int SQ_STEPS = 32;
  localparam int CORDIC_STEPS = 21;
  localparam int SQ_LAT = SQ_STEPS;
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int COS_LAT = 3 + SQ_LAT + CORDIC_LAT;
  localparam int KMAX = NW - 32;

  localparam logic signed [ZW-1:0] HALF_PI_Q20 = 25'sd1647099;
  localparam logic signed [AW+1:0] PI_Q14 = 20'sd51472;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLAMP = 2'd1,
    ST_ZERO  = 2'd2
  } status_t;

  typedef struct packed {
    logic [SW-1:0] v;
    logic [SW-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic signed [AW-1:0] turn;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] psh;
    logic signed [AW-1:0] pel;
    logic                 zero;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:  a = 25'sd823550;
      5'd1:  a = 25'sd486170;
      5'd2:  a = 25'sd256879;
      5'd3:  a = 25'sd130396;
      5'd4:  a = 25'sd65451;
      5'd5:  a = 25'sd32757;
      5'd6:  a = 25'sd16383;
      5'd7:  a = 25'sd8192;
      5'd8:  a = 25'sd4096;
      5'd9:  a = 25'sd2048;
      5'd10: a = 25'sd1024;
      5'd11: a = 25'sd512;
      5'd12: a = 25'sd256;
      5'd13: a = 25'sd128;
      5'd14: a = 25'sd64;
      5'd15: a = 25'sd32;
      5'd16: a = 25'sd16;
      5'd17: a = 25'sd8;
      5'd18: a = 25'sd4;
      5'd19: a = 25'sd2;
      5'd20: a = 25'sd1;
      default: a = 25'sd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ikarm_sqrt_cell.sv -----
`default_nettype none
module ikarm_sqrt_cell (
  input  wire logic            clk,
  input  wire logic            adv,
  input  wire logic [4:0]      step,
  input  wire ikarm_pkg::sqrt_t d_in,
  output ikarm_pkg::sqrt_t     d_out
);
  import ikarm_pkg::*;

  logic [5:0]    sh;
  logic [SW-1:0] bitv;
  logic [SW-1:0] trial;

  always_comb begin
    sh    = 6'd62 - {step, 1'b0};
    bitv  = {{(SW-1){1'b0}}, 1'b1} << sh;
    trial = d_in.res + bitv;
  end

  // one result bit per cell: restoring square root
  always_ff @(posedge clk) begin
    if (adv) begin
      if (d_in.v >= trial) begin
        d_out.v   <= d_in.v - trial;
        d_out.res <= (d_in.res >> 1) + bitv;
      end else begin
        d_out.v   <= d_in.v;
        d_out.res <= d_in.res >> 1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ikarm_isqrt.sv -----
`default_nettype none
module ikarm_isqrt (
  input  wire logic                     clk,
  input  wire logic                     adv,
  input  wire logic [ikarm_pkg::SW-1:0] v,
  output logic [31:0]                   root
);
  import ikarm_pkg::*;

  sqrt_t ch [0:SQ_STEPS];

  assign ch[0] = '{v: v, res: '0};

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_cell
    ikarm_sqrt_cell u_cell (
      .clk   (clk),
      .adv   (adv),
      .step  (5'(i)),
      .d_in  (ch[i]),
      .d_out (ch[i+1])
    );
  end

  assign root = ch[SQ_STEPS].res[31:0];

endmodule
`default_nettype wire

// ----- rtl/core/ikarm_cordic_cell.sv -----
`default_nettype none
module ikarm_cordic_cell (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire logic [4:0]        step,
  input  wire ikarm_pkg::cordic_t d_in,
  output ikarm_pkg::cordic_t     d_out
);
  import ikarm_pkg::*;

  logic signed [CW-1:0] xi, yi, xs, ys;
  logic signed [ZW-1:0] a;

  always_comb begin
    xi = d_in.x;
    yi = d_in.y;
    xs = xi >>> step;
    ys = yi >>> step;
    a  = atan_q20(step);
  end

  // vectoring rotation: drive y toward zero
  always_ff @(posedge clk) begin
    if (adv) begin
      d_out.zero <= d_in.zero;
      if (yi > 0) begin
        d_out.x <= xi + ys;
        d_out.y <= yi - xs;
        d_out.z <= d_in.z + a;
      end else begin
        d_out.x <= xi - ys;
        d_out.y <= yi + xs;
        d_out.z <= d_in.z - a;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ikarm_atan2.sv -----
`default_nettype none
module ikarm_atan2 (
  input  wire logic                            clk,
  input  wire logic                            adv,
  input  wire logic signed [31:0]              y_in,
  input  wire logic signed [31:0]              x_in,
  output logic signed [ikarm_pkg::AW-1:0]      angle
);
  import ikarm_pkg::*;

  cordic_t              ch [0:CORDIC_STEPS];
  logic signed [CW-1:0] xe, ye;
  logic signed [ZW-1:0] zr;

  always_comb begin
    xe = {{(CW-32){x_in[31]}}, x_in};
    ye = {{(CW-32){y_in[31]}}, y_in};
  end

  // quadrant pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (adv) begin
      ch[0].zero <= (x_in == 32'sd0) && (y_in == 32'sd0);
      if (xe < 0) begin
        if (ye >= 0) begin
          ch[0].x <= ye;
          ch[0].y <= -xe;
          ch[0].z <= HALF_PI_Q20;
        end else begin
          ch[0].x <= -ye;
          ch[0].y <= xe;
          ch[0].z <= -HALF_PI_Q20;
        end
      end else begin
        ch[0].x <= xe;
        ch[0].y <= ye;
        ch[0].z <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    ikarm_cordic_cell u_cell (
      .clk   (clk),
      .adv   (adv),
      .step  (5'(i)),
      .d_in  (ch[i]),
      .d_out (ch[i+1])
    );
  end

  assign zr = (ch[CORDIC_STEPS].z + 25'sd32) >>> 6;

  // round Q20 to Q3.14; a zero input vector gives angle zero
  always_ff @(posedge clk) begin
    if (adv) begin
      angle <= ch[CORDIC_STEPS].zero ? '0 : zr[AW-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ikarm_cos_angle.sv -----
`default_nettype none
module ikarm_cos_angle (
  input  wire logic                            clk,
  input  wire logic                            adv,
  input  wire logic signed [ikarm_pkg::NW-1:0] n,
  input  wire logic [ikarm_pkg::NW-1:0]        d,
  output logic signed [ikarm_pkg::AW-1:0]      ang
);
  import ikarm_pkg::*;

  logic signed [NW-1:0] nk, n_sel;
  logic [NW-1:0]        dk, d_sel;
  logic signed [31:0]   n1;
  logic [31:0]          d1, na;
  logic [SW-1:0]        nn, dd, diff;
  logic signed [31:0]   n_d [2:SQ_LAT+3];
  logic [31:0]          root;

  // smallest common halving that brings both below 2^31
  always_comb begin
    n_sel = n;
    d_sel = d;
    nk    = n;
    dk    = d;
    for (int k = KMAX; k >= 0; k--) begin
      nk = n >>> k;
      dk = d >> k;
      if (((&nk[NW-1:31]) || !(|nk[NW-1:31])) &&
          !((&nk[NW-1:31]) && (nk[30:0] == 31'd0)) &&
          !(|dk[NW-1:31])) begin
        n_sel = nk;
        d_sel = dk;
      end
    end
  end

  assign na = n1[31] ? 32'(-n1) : 32'(n1);

  always_ff @(posedge clk) begin
    if (adv) begin
      n1     <= n_sel[31:0];
      d1     <= d_sel[31:0];
      nn     <= na * na;
      dd     <= d1 * d1;
      n_d[2] <= n1;
      diff   <= (nn >= dd) ? nn - dd : dd - nn;
      for (int i = 3; i <= SQ_LAT + 3; i++) begin
        n_d[i] <= n_d[i-1];
      end
    end
  end

  ikarm_isqrt u_sqrt (
    .clk  (clk),
    .adv  (adv),
    .v    (diff),
    .root (root)
  );

  ikarm_atan2 u_atan (
    .clk   (clk),
    .adv   (adv),
    .y_in  (root),
    .x_in  (n_d[SQ_LAT+3]),
    .angle (ang)
  );

endmodule
`default_nettype wire

// ----- rtl/core/two_link_arm_inverse_kinematics.sv -----
// Channel  | Handshake           | Word
// ---------+---------------------+------------------------------------------------
// input    | in_valid / in_stall | target_radius, target_height, turntable_angle,
//          |                     | tool_pitch, tool_roll, prev_shoulder, prev_elbow
// output   | out_valid/out_stall | turntable_cmd, shoulder_cmd, elbow_cmd,
//          |                     | wrist_pitch_cmd, wrist_roll_cmd, status
// config   | APB write/read      | upper_link_length @0x0, lower_link_length @0x4
//
// One word enters per cycle unless a stalled output word holds the chain.
// The chain: squares (2), radius square root (32 cells), law-of-cosines
// setup (1), normalize/square/diff (3), root (32 cells), CORDIC (pre-rotation,
// cells, rounding), joint select and wrist (2).
// A stalled output word freezes the whole chain, and in_stall follows it.
// rst clears the valid bits and reloads both link lengths; derived link
// terms follow a write through the product and then the sum registers.
`default_nettype none
module two_link_arm_inverse_kinematics (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [ikarm_pkg::PW-1:0] target_radius,
  input  wire logic signed [ikarm_pkg::PW-1:0] target_height,
  input  wire logic signed [ikarm_pkg::AW-1:0] turntable_angle,
  input  wire logic signed [ikarm_pkg::AW-1:0] tool_pitch,
  input  wire logic signed [ikarm_pkg::AW-1:0] tool_roll,
  input  wire logic signed [ikarm_pkg::AW-1:0] prev_shoulder,
  input  wire logic signed [ikarm_pkg::AW-1:0] prev_elbow,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [ikarm_pkg::AW-1:0]      turntable_cmd,
  output logic signed [ikarm_pkg::AW-1:0]      shoulder_cmd,
  output logic signed [ikarm_pkg::AW-1:0]      elbow_cmd,
  output logic signed [ikarm_pkg::AW-1:0]      wrist_pitch_cmd,
  output logic signed [ikarm_pkg::AW-1:0]      wrist_roll_cmd,
  output logic [1:0]                           status
);
  import ikarm_pkg::*;

  // pipeline timeline, in cycles after acceptance
  localparam int T_R2  = 2;
  localparam int T_R   = T_R2 + SQ_LAT;
  localparam int T_NS  = T_R + 1;
  localparam int T_ANG = T_NS + COS_LAT;
  localparam int T_GAM = T_ANG - CORDIC_LAT;
  localparam int T_SEL = T_ANG + 1;
  localparam int T_OUT = T_SEL + 1;

  // link lengths and their derived products
  logic [LW-1:0]       l0, l1;
  logic [2*LW-1:0]     l0sq, l1sq, l01;
  logic signed [47:0]  lsd;
  logic [47:0]         lss, de_c;

  logic                adv;
  logic [T_OUT:0]      vld;
  side_t               sd [0:T_SEL];

  logic signed [47:0]  px, py;
  logic [47:0]         x2, y2, r2;
  logic [47:0]         r2d [T_R2:T_R];
  logic [31:0]         root_r;

  logic signed [NW-1:0] ns, ne;
  logic [NW-1:0]        ds, de;
  logic                 clo_c, chi_c;
  logic [1:0]           cl [T_NS+1:T_ANG];   // {high clamp, low clamp}

  logic signed [AW-1:0] beta, eta_raw, gamma;

  logic signed [AW+1:0] s1, s2, eta, e1, e2, sh, el;
  logic signed [AW+2:0] d1, d2, f1, f2, a1, a2, b1, b2;
  status_t              st;
  logic signed [AW+3:0] wp;

  // ---------------- configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {{(32-LW){1'b0}}, l1} : {{(32-LW){1'b0}}, l0};

  always_ff @(posedge clk) begin
    if (rst) begin
      l0 <= 23'd65536;
      l1 <= 23'd65536;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        l1 <= pwdata[LW-1:0];
      end else begin
        l0 <= pwdata[LW-1:0];
      end
    end
  end

  // products first, then sums from the registered products
  always_ff @(posedge clk) begin
    l0sq <= l0 * l0;
    l1sq <= l1 * l1;
    l01  <= l0 * l1;
    lsd  <= $signed({2'b00, l0sq}) - $signed({2'b00, l1sq});
    lss  <= {2'b00, l0sq} + {2'b00, l1sq};
    de_c <= {1'b0, l01, 1'b0};
  end

  // ---------------- flow control: the whole chain advances together
  assign adv       = !(vld[T_OUT] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[T_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[T_OUT-1:0], in_valid};
    end
  end

  // ---------------- side data shift line
  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0].x     <= target_radius;
      sd[0].y     <= target_height;
      sd[0].turn  <= turntable_angle;
      sd[0].pitch <= tool_pitch;
      sd[0].roll  <= tool_roll;
      sd[0].psh   <= prev_shoulder;
      sd[0].pel   <= prev_elbow;
      sd[0].zero  <= (target_radius == '0) && (target_height == '0);
      for (int i = 1; i <= T_SEL; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // ---------------- squared radius
  always_comb begin
    px = sd[0].x * sd[0].x;
    py = sd[0].y * sd[0].y;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x2 <= px;
      y2 <= py;
      r2 <= x2 + y2;
      r2d[T_R2+1] <= r2;
      for (int i = T_R2 + 2; i <= T_R; i++) begin
        r2d[i] <= r2d[i-1];
      end
    end
  end

  ikarm_isqrt u_rsqrt (
    .clk  (clk),
    .adv  (adv),
    .v    ({{(SW-48){1'b0}}, r2}),
    .root (root_r)
  );

  // ---------------- law-of-cosines terms
  always_ff @(posedge clk) begin
    if (adv) begin
      ns <= NW'(lsd) + $signed({{(NW-48){1'b0}}, r2d[T_R]});
      ds <= {{(NW-49){1'b0}}, {25'd0, l0} * {23'd0, root_r[24:0]}, 1'b0};
      ne <= $signed({{(NW-48){1'b0}}, lss}) - $signed({{(NW-48){1'b0}}, r2d[T_R]});
      de <= {{(NW-48){1'b0}}, de_c};
    end
  end

  // out of reach: clamp the elbow cosine
  always_comb begin
    chi_c = ne > $signed(de);
    clo_c = ne < -$signed(de);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cl[T_NS+1] <= {chi_c, clo_c};
      for (int i = T_NS + 2; i <= T_ANG; i++) begin
        cl[i] <= cl[i-1];
      end
    end
  end

  ikarm_cos_angle u_shoulder (
    .clk (clk),
    .adv (adv),
    .n   (ns),
    .d   (ds),
    .ang (beta)
  );

  ikarm_cos_angle u_elbow (
    .clk (clk),
    .adv (adv),
    .n   (ne),
    .d   (de),
    .ang (eta_raw)
  );

  ikarm_atan2 u_gamma (
    .clk   (clk),
    .adv   (adv),
    .y_in  (32'(sd[T_GAM].y)),
    .x_in  (32'(sd[T_GAM].x)),
    .angle (gamma)
  );

  // ---------------- pick the solution nearer the previous pose and set status
  always_comb begin
    s1  = 20'(gamma) - 20'(beta);
    s2  = 20'(gamma) + 20'(beta);
    d1  = 21'(sd[T_ANG].psh) - 21'(s1);
    d2  = 21'(sd[T_ANG].psh) - 21'(s2);
    a1  = d1[AW+2] ? -d1 : d1;
    a2  = d2[AW+2] ? -d2 : d2;
    if (cl[T_ANG][1]) begin
      eta = '0;
    end else if (cl[T_ANG][0]) begin
      eta = PI_Q14;
    end else begin
      eta = 20'(eta_raw);
    end
    e1  = PI_Q14 - eta;
    e2  = eta - PI_Q14;
    f1  = 21'(sd[T_ANG].pel) - 21'(e1);
    f2  = 21'(sd[T_ANG].pel) - 21'(e2);
    b1  = f1[AW+2] ? -f1 : f1;
    b2  = f2[AW+2] ? -f2 : f2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sh <= (a1 < a2) ? s1 : s2;
      el <= (b1 < b2) ? e1 : e2;
      if (sd[T_ANG].zero) begin
        st <= ST_ZERO;
      end else if (cl[T_ANG] != 2'b00) begin
        st <= ST_CLAMP;
      end else begin
        st <= ST_OK;
      end
    end
  end

  // ---------------- wrist pitch and output register
  assign wp = 22'(sd[T_SEL].pitch) - 22'(sh) - 22'(el);

  always_ff @(posedge clk) begin
    if (adv) begin
      turntable_cmd  <= sd[T_SEL].turn;
      wrist_roll_cmd <= sd[T_SEL].roll;
      shoulder_cmd   <= sh[AW-1:0];
      elbow_cmd      <= el[AW-1:0];
      status         <= st;
      if (wp > 22'sd131071) begin
        wrist_pitch_cmd <= 18'sd131071;
      end else if (wp < -22'sd131072) begin
        wrist_pitch_cmd <= 18'sh20000;
      end else begin
        wrist_pitch_cmd <= wp[AW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ikarm_checker.sv -----
`default_nettype none
module ikarm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] status
);

  // a waiting word is held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // input stalls exactly when the output word is held
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // status code three is never produced
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("bad status code");

endmodule

bind two_link_arm_inverse_kinematics ikarm_checker u_ikarm_checker (.*);
`default_nettype wire

// ----- tb/tb_two_link_arm_inverse_kinematics.sv -----
`default_nettype none
module tb_two_link_arm_inverse_kinematics;
  import ikarm_pkg::*;

  localparam int ANG_LO = -131072;
  localparam int ANG_HI = 131071;
  localparam int PIPE_LAT = 96;
  localparam int WATCHDOG = 4000;
  localparam logic [2:0] ADDR_UPPER = 3'h0;
  localparam logic [2:0] ADDR_LOWER = 3'h4;
  localparam longint PI_Q14_C = 51472;
  localparam longint HALF_PI_Q20_C = 1647099;

  typedef struct {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic signed [AW-1:0] turn;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] psh;
    logic signed [AW-1:0] pel;
  } target_t;

  typedef struct {
    logic signed [AW-1:0] turn;
    logic signed [AW-1:0] sh;
    logic signed [AW-1:0] el;
    logic signed [AW-1:0] wp;
    logic signed [AW-1:0] roll;
    status_t              st;
  } joints_t;

  // Arctangent table in Q20 radians, one entry per rotation step.
  function automatic longint atan_step(int i);
    longint tbl[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return tbl[i];
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'h4000_0000_0000_0000;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return longint'(res);
  endfunction

  // Vector-mode rotation: Q3.14 angle of (x, y).
  function automatic longint angle_of(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q20_C;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q20_C;
      end
    end
    for (int i = 0; i < 21; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    return (z + 32) >>> 6;
  endfunction

  // Angle whose cosine is n/d; beyond +-1 the magnitude of n*n - d*d is used.
  function automatic longint law_cos_angle(longint n, longint d);
    longint unsigned nn, dd, diff;
    while (n >= 64'sd2147483648 || n <= -64'sd2147483648 || d >= 64'sd2147483648) begin
      n = n >>> 1;
      d = d >>> 1;
    end
    nn = n * n;
    dd = d * d;
    diff = nn >= dd ? nn - dd : dd - nn;
    return angle_of(isqrt(diff), n);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  class joint_scoreboard;
    longint l0, l1;
    joints_t pending[$];
    int errors;

    function void note_target(target_t t);
      longint x, y, r2, r, beta, gamma, s1, s2, sh, ne, de, eta, e1, e2, el, wp;
      joints_t j;
      x = t.x; y = t.y;
      r2 = x * x + y * y;
      r = isqrt(r2);
      j.st = ST_OK;
      beta = law_cos_angle(l0 * l0 + r2 - l1 * l1, 2 * l0 * r);
      gamma = angle_of(y, x);
      s1 = gamma - beta;
      s2 = gamma + beta;
      sh = (mag(t.psh - s1) < mag(t.psh - s2)) ? s1 : s2;
      ne = l0 * l0 + l1 * l1 - r2;
      de = 2 * l0 * l1;
      if (ne > de) begin
        eta = 0; j.st = ST_CLAMP;
      end else if (ne < -de) begin
        eta = PI_Q14_C; j.st = ST_CLAMP;
      end else begin
        eta = law_cos_angle(ne, de);
      end
      e1 = PI_Q14_C - eta;
      e2 = eta - PI_Q14_C;
      el = (mag(t.pel - e1) < mag(t.pel - e2)) ? e1 : e2;
      if (r2 == 0) j.st = ST_ZERO;
      wp = t.pitch - sh - el;
      if (wp > ANG_HI) wp = ANG_HI;
      if (wp < ANG_LO) wp = ANG_LO;
      j.turn = t.turn; j.sh = sh[AW-1:0]; j.el = el[AW-1:0];
      j.wp = wp[AW-1:0]; j.roll = t.roll;
      pending.push_back(j);
    endfunction

    function void check_joints(joints_t a);
      joints_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, actual sh=%0d el=%0d", $time, a.sh, a.el);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.turn !== e.turn) begin
        $display("%0t: turntable exp %0d act %0d", $time, e.turn, a.turn); errors++;
      end
      if (a.sh !== e.sh) begin
        $display("%0t: shoulder exp %0d act %0d", $time, e.sh, a.sh); errors++;
      end
      if (a.el !== e.el) begin
        $display("%0t: elbow exp %0d act %0d", $time, e.el, a.el); errors++;
      end
      if (a.wp !== e.wp) begin
        $display("%0t: wrist pitch exp %0d act %0d", $time, e.wp, a.wp); errors++;
      end
      if (a.roll !== e.roll) begin
        $display("%0t: wrist roll exp %0d act %0d", $time, e.roll, a.roll); errors++;
      end
      if (a.st !== e.st) begin
        $display("%0t: status exp %0d act %0d", $time, e.st, a.st); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall;
  logic signed [PW-1:0] target_radius = '0, target_height = '0;
  logic signed [AW-1:0] turntable_angle = '0, tool_pitch = '0, tool_roll = '0;
  logic signed [AW-1:0] prev_shoulder = '0, prev_elbow = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [AW-1:0] turntable_cmd, shoulder_cmd, elbow_cmd, wrist_pitch_cmd;
  logic signed [AW-1:0] wrist_roll_cmd;
  logic [1:0] status;

  joint_scoreboard sb;
  int idle_cycles = 0;
  bit calm = 1'b0;       // no idling on either side near the end
  bit hold_off = 1'b0;   // receiver long hold-off requested

  always #5 clk = ~clk;

  two_link_arm_inverse_kinematics u_dut (.*);

  // Sample outputs, score accepted words and count idle cycles on the rising edge.
  always @(posedge clk) begin
    joints_t a;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        a.turn = turntable_cmd; a.sh = shoulder_cmd; a.el = elbow_cmd;
        a.wp = wrist_pitch_cmd; a.roll = wrist_roll_cmd; a.st = status_t'(status);
        sb.check_joints(a);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_two_link_arm_inverse_kinematics: FAIL");
      $finish;
    end
  end

  // Receiver: stall in random bursts, plus one long hold-off on request.
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(negedge clk);
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_UPPER) sb.l0 = data[LW-1:0];
    else sb.l1 = data[LW-1:0];
    repeat (3) @(negedge clk);
  endtask

  // Offer one word, hold it until accepted, then maybe idle a burst.
  task automatic send_target(target_t t, bit may_idle);
    target_radius <= t.x; target_height <= t.y; turntable_angle <= t.turn;
    tool_pitch <= t.pitch; tool_roll <= t.roll;
    prev_shoulder <= t.psh; prev_elbow <= t.pel;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_target(t);
    @(negedge clk);
    if (may_idle && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT / 4) @(negedge clk);
  endtask

  function automatic target_t rand_target(int mode);
    target_t t;
    longint reach;
    reach = sb.l0 + sb.l1;
    t.turn = $urandom; t.pitch = $urandom; t.roll = $urandom;
    t.psh = $urandom; t.pel = $urandom;
    case (mode)
      0: begin
        t.x = $urandom; t.y = $urandom;
      end
      default: begin
        // targets near the workspace, mostly reachable
        t.x = $signed(24'($urandom_range(0, 2 * reach) - reach));
        t.y = $signed(24'($urandom_range(0, 2 * reach) - reach));
      end
    endcase
    return t;
  endfunction

  initial begin
    target_t t;
    int lens[6][2] = '{'{65536, 65536}, '{1, 1}, '{8388607, 8388607},
                       '{98304, 40000}, '{30000, 120000}, '{1, 8388607}};
    sb = new();
    sb.l0 = 65536; sb.l1 = 65536;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, zero radius, clamps, wrist saturation; the rest are random.
    for (int k = 0; k < 20; k++) begin
      t.x = '0; t.y = '0; t.turn = '0; t.pitch = '0; t.roll = '0; t.psh = '0; t.pel = '0;
      case (k)
        1: begin t.x = 24'sh7FFFFF; t.y = 24'sh7FFFFF; end
        2: begin t.x = -24'sh800000; t.y = -24'sh800000; end
        3: begin t.x = 65536; t.y = 65536; end
        4: begin t.x = 131072; end
        5: begin t.x = -65536; t.y = 1; end
        6: begin t.x = 100; t.psh = 18'sh1FFFF; t.pel = -18'sh20000; end
        7: begin t.x = 80000; t.pitch = 18'sh1FFFF; t.psh = -18'sh20000;
                 t.pel = -18'sh20000; end
        8: begin t.x = 80000; t.pitch = -18'sh20000; t.psh = 18'sh1FFFF;
                 t.pel = 18'sh1FFFF; end
        9: begin t.turn = 18'sh1FFFF; t.roll = -18'sh20000; t.y = -90000; end
        10: begin t.turn = -18'sh20000; t.roll = 18'sh1FFFF; t.x = -90000; end
        11: begin t.x = 0; t.y = -131072; end
        12: begin t.x = -1; t.y = 0; end
        default: t = rand_target(k & 1);
      endcase
      send_target(t, 1'b0);
    end
    drain();

    // Random phases over several link settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ADDR_UPPER, lens[ph][0]);
      write_reg(ADDR_LOWER, lens[ph][1]);
      for (int k = 0; k < 150; k++) begin
        if (ph == 5) calm = 1'b1;
        if (ph == 2 && k == 10) hold_off = 1'b1;
        send_target(rand_target($urandom_range(0, 3) == 0 ? 0 : 1), 1'b1);
        if (ph == 0 && k == 30) begin
          // zero radius with random angles
          t = rand_target(1); t.x = '0; t.y = '0;
          send_target(t, 1'b1);
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_two_link_arm_inverse_kinematics: PASS");
    else
      $display("tb_two_link_arm_inverse_kinematics: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/ikarm_pkg.sv
rtl/core/ikarm_sqrt_cell.sv
rtl/core/ikarm_isqrt.sv
rtl/core/ikarm_cordic_cell.sv
rtl/core/ikarm_atan2.sv
rtl/core/ikarm_cos_angle.sv
rtl/core/two_link_arm_inverse_kinematics.sv
rtl/core/ikarm_checker.sv
tb/tb_two_link_arm_inverse_kinematics.sv
